FILE: rtl/rhc_pkg.sv
// Package for the RGB/HSV byte converter: item types, codes, constants and the divider step.
`default_nettype none

package rhc_pkg;

	typedef enum logic {
		FUNC_HSV2RGB = 1'b0,
		FUNC_RGB2HSV = 1'b1
	} func_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] in_first;
		logic [7:0] in_second;
		logic [7:0] in_third;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_first;
		logic [7:0] out_second;
		logic [7:0] out_third;
	} out_item_t;

	typedef enum logic [1:0] {
		HSEL_RED   = 2'd0,
		HSEL_GREEN = 2'd1,
		HSEL_BLUE  = 2'd2
	} hue_sel_t;

	localparam logic [7:0] HUE_SPAN  = 8'd43;
	localparam logic [7:0] OFS_RED   = 8'd0;
	localparam logic [7:0] OFS_GREEN = 8'd85;
	localparam logic [7:0] OFS_BLUE  = 8'd171;
	localparam logic [7:0] FULL      = 8'd255;
	localparam logic [7:0] REM_SCALE = 8'd6;
	localparam int         PROD_SHIFT = 8;

	localparam logic [2:0] REGION_TOP = 3'd5;

	// Two restoring division steps. st = {partial remainder, numerator bits / quotient bits}.
	// The remainder must be below d on entry; quotient bits shift in at the bottom.
	function automatic logic [15:0] div2(logic [15:0] st, logic [7:0] d);
		logic [8:0] t;
		logic [7:0] r;
		logic [7:0] nq;
		r  = st[15:8];
		nq = st[7:0];
		for (int i = 0; i < 2; i++) begin
			t  = {r, nq[7]};
			nq = {nq[6:0], 1'b0};
			if (t >= {1'b0, d}) begin
				r     = 8'(t - {1'b0, d});
				nq[0] = 1'b1;
			end else begin
				r = t[7:0];
			end
		end
		return {r, nq};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rgb_hsv_byte_converter.sv
// Top level: seven-stage pipelined 8-bit RGB <-> HSV converter.
`default_nettype none

// Takes one pixel per clock while the output is not stalled and returns one converted pixel per item, in order.
// Each item passes through stages s1..s7 (s1 being loaded at acceptance and s7 being
// the output register).
// The latency is set by the RGB-to-HSV divides: saturation and hue quotients
// come out of four pipelined stages that each resolve two quotient bits.
// A stalled output holds the whole pipeline; req_ready is high whenever the
// output register is empty or being taken.
module rgb_hsv_byte_converter
	import rhc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire in_item_t  req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output out_item_t      rsp
);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	assign adv       = !vld_s7 || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// ---------------- stage 1: region / remainder, max / min
	logic [2:0] region_c;
	logic [7:0] base_c;
	logic [7:0] mx_c, mn_c;
	hue_sel_t   hsel_c;

	always_comb begin
		if (req.in_first < 8'd43) begin
			region_c = 3'd0; base_c = 8'd0;
		end else if (req.in_first < 8'd86) begin
			region_c = 3'd1; base_c = 8'd43;
		end else if (req.in_first < 8'd129) begin
			region_c = 3'd2; base_c = 8'd86;
		end else if (req.in_first < 8'd172) begin
			region_c = 3'd3; base_c = 8'd129;
		end else if (req.in_first < 8'd215) begin
			region_c = 3'd4; base_c = 8'd172;
		end else begin
			region_c = REGION_TOP; base_c = 8'd215;
		end
	end

	always_comb begin
		mx_c = req.in_first;
		mn_c = req.in_first;
		if (req.in_second > mx_c) mx_c = req.in_second;
		if (req.in_third > mx_c)  mx_c = req.in_third;
		if (req.in_second < mn_c) mn_c = req.in_second;
		if (req.in_third < mn_c)  mn_c = req.in_third;
		if (mx_c == req.in_first)       hsel_c = HSEL_RED;
		else if (mx_c == req.in_second) hsel_c = HSEL_GREEN;
		else                            hsel_c = HSEL_BLUE;
	end

	func_t      func_s1;
	logic [7:0] a_s1, b_s1, c_s1;
	logic [2:0] region_s1;
	logic [7:0] rem_s1;
	logic [7:0] mx_s1, mn_s1;
	hue_sel_t   hsel_s1;

	// ---------------- stage 2: products and division numerators
	logic [8:0] diff_c;
	logic       neg_c;
	logic [7:0] mag_c;
	logic [7:0] delta_c;

	always_comb begin
		delta_c = mx_s1 - mn_s1;
		case (hsel_s1)
			HSEL_RED:   diff_c = {1'b0, b_s1} - {1'b0, c_s1};
			HSEL_GREEN: diff_c = {1'b0, c_s1} - {1'b0, a_s1};
			default:    diff_c = {1'b0, a_s1} - {1'b0, b_s1};
		endcase
		neg_c = diff_c[8];
		mag_c = neg_c ? 8'(-diff_c) : diff_c[7:0];
	end

	func_t       func_s2;
	logic [7:0]  v_s2;
	logic        szero_s2;
	logic [2:0]  region_s2;
	logic [15:0] pp_s2, sr_s2, st_s2;
	logic [7:0]  mx_s2, delta_s2;
	hue_sel_t    hsel_s2;
	logic        neg_s2;
	logic [15:0] ns_s2, nh_s2;

	// ---------------- stage 3: q / t products, division steps begin
	func_t       func_s3;
	logic [7:0]  v_s3, p_s3, q_s3, t_s3;
	logic        szero_s3;
	logic [2:0]  region_s3;
	logic [7:0]  mx_s3, delta_s3;
	hue_sel_t    hsel_s3;
	logic        neg_s3;
	logic [15:0] ds_s3, dh_s3;
	logic [15:0] qq_c, tt_c;

	always_comb begin
		qq_c = v_s2 * (FULL - sr_s2[15:PROD_SHIFT]);
		tt_c = v_s2 * (FULL - st_s2[15:PROD_SHIFT]);
	end

	// ---------------- stage 4: region routing
	out_item_t   rgb_c;

	always_comb begin
		if (szero_s3) begin
			rgb_c = '{v_s3, v_s3, v_s3};
		end else begin
			case (region_s3)
				3'd0:    rgb_c = '{v_s3, t_s3, p_s3};
				3'd1:    rgb_c = '{q_s3, v_s3, p_s3};
				3'd2:    rgb_c = '{p_s3, v_s3, t_s3};
				3'd3:    rgb_c = '{p_s3, q_s3, v_s3};
				3'd4:    rgb_c = '{t_s3, p_s3, v_s3};
				default: rgb_c = '{v_s3, p_s3, q_s3};
			endcase
		end
	end

	func_t       func_s4, func_s5, func_s6;
	out_item_t   rgb_s4, rgb_s5, rgb_s6;
	logic [7:0]  mx_s4, mx_s5, mx_s6;
	logic [7:0]  delta_s4, delta_s5;
	hue_sel_t    hsel_s4, hsel_s5, hsel_s6;
	logic        neg_s4, neg_s5, neg_s6;
	logic [15:0] ds_s4, ds_s5, ds_s6;
	logic [15:0] dh_s4, dh_s5, dh_s6;

	// ---------------- stage 7: hue assembly and output
	logic [7:0] sq_c, hq_c, ofs_c, hue_c;
	out_item_t  hsv_c;

	always_comb begin
		sq_c = ds_s6[7:0];
		hq_c = dh_s6[7:0];
		case (hsel_s6)
			HSEL_RED:   ofs_c = OFS_RED;
			HSEL_GREEN: ofs_c = OFS_GREEN;
			default:    ofs_c = OFS_BLUE;
		endcase
		hue_c = ofs_c + (neg_s6 ? 8'(-hq_c) : hq_c);
		if (mx_s6 == 8'd0)
			hsv_c = '{8'd0, 8'd0, 8'd0};
		else if (sq_c == 8'd0)
			hsv_c = '{8'd0, 8'd0, mx_s6};
		else
			hsv_c = '{hue_c, sq_c, mx_s6};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1
			func_s1   <= req.func;
			a_s1      <= req.in_first;
			b_s1      <= req.in_second;
			c_s1      <= req.in_third;
			region_s1 <= region_c;
			rem_s1    <= 8'((req.in_first - base_c) * REM_SCALE);
			mx_s1     <= mx_c;
			mn_s1     <= mn_c;
			hsel_s1   <= hsel_c;
			// s2
			func_s2   <= func_s1;
			v_s2      <= c_s1;
			szero_s2  <= (b_s1 == 8'd0);
			region_s2 <= region_s1;
			pp_s2     <= c_s1 * (FULL - b_s1);
			sr_s2     <= b_s1 * rem_s1;
			st_s2     <= b_s1 * (FULL - rem_s1);
			mx_s2     <= mx_s1;
			delta_s2  <= delta_c;
			hsel_s2   <= hsel_s1;
			neg_s2    <= neg_c;
			ns_s2     <= {delta_c, 8'd0} - {8'd0, delta_c};
			nh_s2     <= mag_c * HUE_SPAN;
			// s3
			func_s3   <= func_s2;
			v_s3      <= v_s2;
			szero_s3  <= szero_s2;
			region_s3 <= region_s2;
			p_s3      <= pp_s2[15:PROD_SHIFT];
			q_s3      <= qq_c[15:PROD_SHIFT];
			t_s3      <= tt_c[15:PROD_SHIFT];
			mx_s3     <= mx_s2;
			delta_s3  <= delta_s2;
			hsel_s3   <= hsel_s2;
			neg_s3    <= neg_s2;
			ds_s3     <= div2(ns_s2, mx_s2);
			dh_s3     <= div2(nh_s2, delta_s2);
			// s4
			func_s4   <= func_s3;
			rgb_s4    <= rgb_c;
			mx_s4     <= mx_s3;
			delta_s4  <= delta_s3;
			hsel_s4   <= hsel_s3;
			neg_s4    <= neg_s3;
			ds_s4     <= div2(ds_s3, mx_s3);
			dh_s4     <= div2(dh_s3, delta_s3);
			// s5
			func_s5   <= func_s4;
			rgb_s5    <= rgb_s4;
			mx_s5     <= mx_s4;
			delta_s5  <= delta_s4;
			hsel_s5   <= hsel_s4;
			neg_s5    <= neg_s4;
			ds_s5     <= div2(ds_s4, mx_s4);
			dh_s5     <= div2(dh_s4, delta_s4);
			// s6
			func_s6   <= func_s5;
			rgb_s6    <= rgb_s5;
			mx_s6     <= mx_s5;
			hsel_s6   <= hsel_s5;
			neg_s6    <= neg_s5;
			ds_s6     <= div2(ds_s5, mx_s5);
			dh_s6     <= div2(dh_s5, delta_s5);
			// s7
			rsp       <= (func_s6 == FUNC_HSV2RGB) ? rgb_s6 : hsv_c;
		end
	end

endmodule

`default_nettype wire
